// ===== sv/go_back_n_sender_window_assert.svh =====
// assertion macros for the go-back-n sender window
`ifndef GO_BACK_N_SENDER_WINDOW_ASSERT_SVH
`define GO_BACK_N_SENDER_WINDOW_ASSERT_SVH

// condition holds at every edge out of reset
`define GBN_ASSERT_HOLDS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("gbn assertion failed");

// consequence holds in the cycle after the antecedent
`define GBN_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gbn assertion failed");

// consequence holds in the same cycle as the antecedent
`define GBN_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gbn assertion failed");

`endif

// ===== sv/gbn_pkg.sv =====
// types and constants shared by the go-back-n sender window
`default_nettype none

package gbn_pkg;

    localparam int SEQ_W     = 32;
    localparam int ELAPSED_W = 17;
    localparam int TCOUNT_W  = 9;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
    localparam logic [TCOUNT_W-1:0]  TCOUNT_MAX  = '1;

    // input operations
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_ACK   = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // transfer phase, also the status field
    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_SENDING = 2'd1;
    localparam logic [1:0] PH_DONE    = 2'd2;
    localparam logic [1:0] PH_FAILED  = 2'd3;

    // result kinds
    localparam logic KIND_SEND   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_WINDOW_SIZE   = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT_TICKS = 2'd1;
    localparam logic [1:0] CFG_RETRY_LIMIT   = 2'd2;
    localparam logic [1:0] CFG_TOTAL_CHUNKS  = 2'd3;

    typedef enum logic [11:0] {
        S_IDLE    = 12'b0000_0000_0001,
        S_ACK_LO  = 12'b0000_0000_0010,
        S_ACK_HI  = 12'b0000_0000_0100,
        S_ACK_INC = 12'b0000_0000_1000,
        S_TICK    = 12'b0000_0001_0000,
        S_TCMP    = 12'b0000_0010_0000,
        S_DCHK    = 12'b0000_0100_0000,
        S_RETX    = 12'b0000_1000_0000,
        S_NPREP1  = 12'b0001_0000_0000,
        S_NPREP2  = 12'b0010_0000_0000,
        S_NEWS    = 12'b0100_0000_0000,
        S_STAT    = 12'b1000_0000_0000
    } t_state;

    typedef struct packed {
        logic [SEQ_W-1:0] a;
        logic [SEQ_W-1:0] b;
        logic             sub;
    } t_alu_req;

    typedef struct packed {
        logic [SEQ_W-1:0] sum;
        logic             carry;
        logic             zero;
    } t_alu_rsp;

endpackage

`default_nettype wire

// ===== sv/gbn_alu.sv =====
// shared 32-bit add / subtract unit with carry and zero flags
`default_nettype none

module gbn_alu
    import gbn_pkg::*;
(
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    logic [SEQ_W:0]   full;
    logic [SEQ_W-1:0] b_eff;

    // subtract is a plus inverted b plus one; carry set means a >= b
    assign b_eff = i_req.sub ? ~i_req.b : i_req.b;
    assign full  = {1'b0, i_req.a} + {1'b0, b_eff} + (SEQ_W+1)'(i_req.sub);

    assign o_rsp.sum   = full[SEQ_W-1:0];
    assign o_rsp.carry = full[SEQ_W];
    assign o_rsp.zero  = (full[SEQ_W-1:0] == '0);

endmodule

`default_nettype wire

// ===== sv/go_back_n_sender_window.sv =====
// go-back-n sender window: top level with sequencer around the shared adder
//
// input channel (i_in_valid / o_in_stall) takes one beat per command: start,
// cumulative ack in i_ack_seq, or a one millisecond tick. each beat yields a
// burst of result beats on the output channel (o_out_valid / i_out_stall):
// zero or more send requests (o_kind = send, o_seq = number to send) and then
// exactly one status beat with o_last high. o_status on every beat of a burst
// is the phase the transfer holds once the command is finished.
// a beat is worked on by a sequencer that steps one 32-bit add / subtract
// unit through the compares and increments, one use per cycle. o_in_stall is
// high from acceptance until the status beat is loaded into the output
// register, so the next command can enter while that beat still waits.
// a command that only needs status goes straight to the status beat; an ack first runs the
// low and high bound checks and the base increment, a tick with the timer on the elapsed
// update and timeout compare, then the done check, resends, budget steps, new sends and status.
// one send beat per cycle while the receiver takes them; when it stalls the
// sequencer holds and the output register keeps its beat unchanged.
// reset (i_rst_n low, synchronous) clears the window, timer, retry count and
// phase to idle and loads register defaults: window 8, timeout 300 ticks,
// retry limit 20, zero chunks. configuration writes take effect at once.
`default_nettype none

module go_back_n_sender_window
    import gbn_pkg::*;
#(
    parameter int WINDOW_MAX = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // configuration write port
    input  logic             i_cfg_wr_en,
    input  logic [1:0]       i_cfg_index,
    input  logic [31:0]      i_cfg_data,
    // command channel
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [1:0]       i_op,
    input  logic [SEQ_W-1:0] i_ack_seq,
    // result channel
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic             o_kind,
    output logic [SEQ_W-1:0] o_seq,
    output logic [1:0]       o_status,
    output logic             o_last
);

    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam logic [CW-1:0] WMAX_C = CW'(WINDOW_MAX);

    // configuration registers
    logic [5:0]           r_window_size;
    logic [15:0]          r_timeout_ticks;
    logic [7:0]           r_retry_limit;
    logic [SEQ_W-1:0]     r_total_chunks;

    // transfer state
    t_state               r_state,   n_state;
    logic [SEQ_W-1:0]     r_base,    n_base;
    logic [SEQ_W-1:0]     r_next,    n_next;
    logic [TCOUNT_W-1:0]  r_tcount,  n_tcount;
    logic                 r_timer_on, n_timer_on;
    logic [ELAPSED_W-1:0] r_elapsed, n_elapsed;
    logic [1:0]           r_phase,   n_phase;

    // per-command working registers
    logic                 r_done,    n_done;
    logic                 r_retx,    n_retx;
    logic [CW-1:0]        r_cnt,     n_cnt;
    logic [CW-1:0]        r_budget,  n_budget;
    logic [SEQ_W-1:0]     r_rseq,    n_rseq;
    logic [SEQ_W-1:0]     r_ack;

    // output register
    logic                 r_out_valid, n_out_valid;
    logic                 r_kind;
    logic [SEQ_W-1:0]     r_seq_o;
    logic [1:0]           r_status;
    logic                 r_last;

    logic                 in_accept;
    logic                 out_free;
    logic                 emit_en;
    logic                 emit_kind;
    logic [SEQ_W-1:0]     emit_seq;
    logic                 emit_last;
    logic [CW-1:0]        win;
    logic [CW-1:0]        room;
    logic [CW-1:0]        cap;
    logic [TCOUNT_W-1:0]  tcount_inc;
    t_alu_req             alu_req;
    t_alu_rsp             alu_rsp;

    gbn_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;

    // effective window: zero acts as one, clipped to WINDOW_MAX
    always_comb begin
        if (r_window_size == '0) begin
            win = CW'(1);
        end else if (r_window_size > 6'(WINDOW_MAX)) begin
            win = WMAX_C;
        end else begin
            win = CW'(r_window_size);
        end
    end

    assign tcount_inc = (r_tcount == TCOUNT_MAX) ? r_tcount : r_tcount + 1'b1;
    assign cap        = WMAX_C - r_cnt;
    assign room       = win - alu_rsp.sum[CW-1:0];

    // operand selection for the shared adder
    always_comb begin
        alu_req = '0;
        case (r_state)
            S_ACK_LO:  alu_req = '{a: r_ack,  b: r_base, sub: 1'b1};
            S_ACK_HI:  alu_req = '{a: r_next, b: r_ack,  sub: 1'b1};
            S_ACK_INC: alu_req = '{a: r_ack,  b: SEQ_W'(1), sub: 1'b0};
            S_TCMP:    alu_req = '{a: SEQ_W'(r_timeout_ticks), b: SEQ_W'(r_elapsed),
                                   sub: 1'b1};
            S_DCHK:    alu_req = '{a: r_base, b: r_total_chunks, sub: 1'b1};
            S_RETX:    alu_req = '{a: r_rseq, b: SEQ_W'(1), sub: 1'b0};
            S_NPREP1:  alu_req = '{a: r_next, b: r_base, sub: 1'b1};
            S_NPREP2:  alu_req = '{a: r_total_chunks, b: r_next, sub: 1'b1};
            S_NEWS:    alu_req = '{a: r_next, b: SEQ_W'(1), sub: 1'b0};
            default:   alu_req = '0;
        endcase
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_base     = r_base;
        n_next     = r_next;
        n_tcount   = r_tcount;
        n_timer_on = r_timer_on;
        n_elapsed  = r_elapsed;
        n_phase    = r_phase;
        n_done     = r_done;
        n_retx     = r_retx;
        n_cnt      = r_cnt;
        n_budget   = r_budget;
        n_rseq     = r_rseq;
        emit_en    = 1'b0;
        emit_kind  = KIND_SEND;
        emit_seq   = '0;
        emit_last  = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_done = 1'b0;
                    n_retx = 1'b0;
                    n_cnt  = '0;
                    if (i_op == OP_START) begin
                        n_base     = '0;
                        n_next     = '0;
                        n_tcount   = '0;
                        n_timer_on = 1'b0;
                        n_elapsed  = '0;
                        n_phase    = PH_SENDING;
                        n_state    = S_DCHK;
                    end else if (r_phase != PH_SENDING) begin
                        n_state = S_STAT;
                    end else if (i_op == OP_ACK) begin
                        n_state = S_ACK_LO;
                    end else if (i_op == OP_TICK && r_timer_on) begin
                        n_state = S_TICK;
                    end else begin
                        n_state = S_DCHK;
                    end
                end
            end
            S_ACK_LO: begin
                // ack below the base is stale
                n_state = alu_rsp.carry ? S_ACK_HI : S_DCHK;
            end
            S_ACK_HI: begin
                // ack must lie below the next unsent number
                n_state = (alu_rsp.carry && !alu_rsp.zero) ? S_ACK_INC : S_DCHK;
            end
            S_ACK_INC: begin
                n_base     = alu_rsp.sum;
                n_timer_on = (alu_rsp.sum != r_next);
                n_elapsed  = '0;
                n_state    = S_DCHK;
            end
            S_TICK: begin
                if (r_elapsed != ELAPSED_MAX) begin
                    n_elapsed = r_elapsed + 1'b1;
                end
                n_state = S_TCMP;
            end
            S_TCMP: begin
                if (!alu_rsp.carry) begin
                    // timeout fired
                    n_timer_on = 1'b0;
                    n_tcount   = tcount_inc;
                    if (tcount_inc > TCOUNT_W'(r_retry_limit)) begin
                        n_phase = PH_FAILED;
                        n_state = S_STAT;
                    end else begin
                        n_timer_on = 1'b1;
                        n_elapsed  = '0;
                        n_retx     = 1'b1;
                        n_rseq     = r_base;
                        n_state    = S_DCHK;
                    end
                end else begin
                    n_state = S_DCHK;
                end
            end
            S_DCHK: begin
                // base does not move from here on, so the final phase is known now
                if (alu_rsp.carry) begin
                    n_done  = 1'b1;
                    n_phase = PH_DONE;
                end
                n_state = r_retx ? S_RETX : S_NPREP1;
            end
            S_RETX: begin
                if (r_rseq == r_next || r_cnt == WMAX_C) begin
                    n_state = S_NPREP1;
                end else if (out_free) begin
                    emit_en  = 1'b1;
                    emit_seq = r_rseq;
                    n_rseq   = alu_rsp.sum;
                    n_cnt    = r_cnt + 1'b1;
                end
            end
            S_NPREP1: begin
                // in-flight count against the window and the per-command cap
                if (alu_rsp.sum < SEQ_W'(win)) begin
                    n_budget = (room < cap) ? room : cap;
                end else begin
                    n_budget = '0;
                end
                n_state = S_NPREP2;
            end
            S_NPREP2: begin
                // chunks left in the transfer
                if (!alu_rsp.carry) begin
                    n_budget = '0;
                end else if (alu_rsp.sum < SEQ_W'(r_budget)) begin
                    n_budget = CW'(alu_rsp.sum);
                end
                n_state = S_NEWS;
            end
            S_NEWS: begin
                if (r_budget == '0) begin
                    n_state = S_STAT;
                end else if (out_free) begin
                    emit_en  = 1'b1;
                    emit_seq = r_next;
                    if (r_base == r_next && !r_timer_on) begin
                        n_timer_on = 1'b1;
                        n_elapsed  = '0;
                    end
                    n_next   = alu_rsp.sum;
                    n_budget = r_budget - 1'b1;
                end
            end
            S_STAT: begin
                if (out_free) begin
                    emit_en   = 1'b1;
                    emit_kind = KIND_STATUS;
                    emit_last = 1'b1;
                    if (r_done) begin
                        n_timer_on = 1'b0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_valid = emit_en || (r_out_valid && i_out_stall);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_base          <= '0;
            r_next          <= '0;
            r_tcount        <= '0;
            r_timer_on      <= 1'b0;
            r_elapsed       <= '0;
            r_phase         <= PH_IDLE;
            r_done          <= 1'b0;
            r_retx          <= 1'b0;
            r_cnt           <= '0;
            r_budget        <= '0;
            r_out_valid     <= 1'b0;
            r_window_size   <= 6'd8;
            r_timeout_ticks <= 16'd300;
            r_retry_limit   <= 8'd20;
            r_total_chunks  <= '0;
        end else begin
            r_state     <= n_state;
            r_base      <= n_base;
            r_next      <= n_next;
            r_tcount    <= n_tcount;
            r_timer_on  <= n_timer_on;
            r_elapsed   <= n_elapsed;
            r_phase     <= n_phase;
            r_done      <= n_done;
            r_retx      <= n_retx;
            r_cnt       <= n_cnt;
            r_budget    <= n_budget;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_WINDOW_SIZE:   r_window_size   <= i_cfg_data[5:0];
                    CFG_TIMEOUT_TICKS: r_timeout_ticks <= i_cfg_data[15:0];
                    CFG_RETRY_LIMIT:   r_retry_limit   <= i_cfg_data[7:0];
                    CFG_TOTAL_CHUNKS:  r_total_chunks  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rseq <= n_rseq;
        if (in_accept) begin
            r_ack <= i_ack_seq;
        end
        if (emit_en) begin
            r_kind   <= emit_kind;
            r_seq_o  <= emit_seq;
            r_status <= n_phase;
            r_last   <= emit_last;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_seq       = r_seq_o;
    assign o_status    = r_status;
    assign o_last      = r_last;

`include "go_back_n_sender_window_assert.svh"

    // window never inverted
    `GBN_ASSERT_HOLDS(a_base_le_next, r_base <= r_next)
    // sends per command bounded by the window maximum
    `GBN_ASSERT_HOLDS(a_cnt_bound, r_cnt <= WMAX_C)
    // an accepted command always blocks the next one by raising the stall
    `GBN_ASSERT_NEXT(a_busy_after_accept, in_accept, o_in_stall)
    // a failed transfer never has its timer running between commands
    `GBN_ASSERT_SAME(a_failed_timer_off, r_state == S_IDLE && r_phase == PH_FAILED,
        !r_timer_on)

endmodule

`default_nettype wire
